// ===== hw/rtl/poll_reply_line_parser_assert.svh =====
// assertion macros for the poll reply line parser
`ifndef POLL_REPLY_LINE_PARSER_ASSERT_SVH
`define POLL_REPLY_LINE_PARSER_ASSERT_SVH

// same-cycle implication
`define PRLP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PRLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/prlp_pkg.sv =====
// ----------------------------------------------------------------------------
// prlp_pkg
// Shared types, codes and constants of the poll reply line parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prlp_pkg;

  localparam int LINE_BUFFER_BYTES_DEF = 256;
  localparam int QUEUE_DEPTH_DEF       = 4;

  localparam logic [2:0] STATUS_NONE      = 3'd0;
  localparam logic [2:0] STATUS_FOUND     = 3'd1;
  localparam logic [2:0] STATUS_MALFORMED = 3'd2;
  localparam logic [2:0] STATUS_ZERO_BYTE = 3'd3;
  localparam logic [2:0] STATUS_TOO_LONG  = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic       is_zero;
    logic       is_nl;
    logic       is_cr;
    logic       is_space;
    logic       is_dec;
    logic       is_hex;
    logic [3:0] nib;
    logic [7:0] ch;
  } byte_class_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] nonce;
    logic [31:0] hash_word;
    logic [63:0] hash_count;
    logic [31:0] last_hash_word;
  } result_t;

  // expected prefix letter, zero past the end
  function automatic logic [7:0] prefix_char(input logic found, input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    if (found) begin
      unique case (idx)
        3'd0: c = "F";
        3'd1: c = "O";
        3'd2: c = "U";
        3'd3: c = "N";
        3'd4: c = "D";
        3'd5: c = " ";
        default: c = 8'h00;
      endcase
    end else begin
      unique case (idx)
        3'd0: c = "N";
        3'd1: c = "O";
        3'd2: c = "N";
        3'd3: c = "E";
        3'd4: c = " ";
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/prlp_front.sv =====
// ----------------------------------------------------------------------------
// prlp_front
// Accepts received bytes and classifies each one for the parser queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prlp_front
  import prlp_pkg::*;
(
  input  logic        push,
  input  logic        q_full,
  input  logic [7:0]  rx_byte,
  output logic        enq,
  output byte_class_t enq_data
);

  logic is_lower;
  logic is_upper;

  assign enq = push && !q_full;

  always_comb begin
    is_lower          = (rx_byte >= "a") && (rx_byte <= "f");
    is_upper          = (rx_byte >= "A") && (rx_byte <= "F");
    enq_data.ch       = rx_byte;
    enq_data.is_zero  = (rx_byte == CH_NUL);
    enq_data.is_nl    = (rx_byte == CH_NL);
    enq_data.is_cr    = (rx_byte == CH_CR);
    enq_data.is_space = (rx_byte == CH_SPACE);
    enq_data.is_dec   = (rx_byte >= "0") && (rx_byte <= "9");
    enq_data.is_hex   = enq_data.is_dec || is_lower || is_upper;
    if (enq_data.is_dec) begin
      enq_data.nib = rx_byte[3:0];
    end else begin
      enq_data.nib = rx_byte[3:0] + 4'd9;
    end
  end

endmodule

// ===== hw/rtl/prlp_queue.sv =====
// ----------------------------------------------------------------------------
// prlp_queue
// Short queue of classified bytes between the front and the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prlp_queue
  import prlp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr,
  input  byte_class_t wr_data,
  input  logic        rd,
  output byte_class_t rd_data,
  output logic        not_empty,
  output logic        is_full,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  byte_class_t   slots [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;

  assign rd_data   = slots[rptr];
  assign not_empty = (count != '0);
  assign is_full   = (count == CW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/prlp_back.sv =====
// ----------------------------------------------------------------------------
// prlp_back
// Line parser: walks the reply layout one byte per cycle and holds the result; an unpopped result stalls it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prlp_back
  import prlp_pkg::*;
#(
  parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  byte_class_t q_data,
  output logic        q_pop,
  input  logic        pop,
  output logic        res_valid,
  output result_t     res
);

  localparam int LW = $clog2(LINE_BUFFER_BYTES);

  localparam logic [3:0] S_PREFIX    = 4'd0;
  localparam logic [3:0] S_NONCE     = 4'd1;
  localparam logic [3:0] S_SP1       = 4'd2;
  localparam logic [3:0] S_HASH      = 4'd3;
  localparam logic [3:0] S_SP2       = 4'd4;
  localparam logic [3:0] S_DEC_FIRST = 4'd5;
  localparam logic [3:0] S_DEC_MORE  = 4'd6;
  localparam logic [3:0] S_LAST      = 4'd7;
  localparam logic [3:0] S_DONE      = 4'd8;

  logic [3:0]    step, step_next;
  logic [2:0]    dcnt, dcnt_next;
  logic [LW-1:0] len, len_next;
  logic          cr_pending, cr_pending_next;
  logic          bad, bad_next;
  logic          found, found_next;
  logic [31:0]   nonce_acc, nonce_acc_next;
  logic [31:0]   hash_acc, hash_acc_next;
  logic [63:0]   count_acc, count_acc_next;
  logic          ovf, ovf_next;
  logic [31:0]   last_acc, last_acc_next;

  logic          emit;
  logic          restart;
  result_t       res_next;
  logic          found_eff;
  logic [2:0]    pfx_len;
  logic [67:0]   dec_sum;

  assign q_pop = q_valid && (!res_valid || pop);

  always_comb begin
    step_next       = step;
    dcnt_next       = dcnt;
    len_next        = len;
    cr_pending_next = cr_pending;
    bad_next        = bad;
    found_next      = found;
    nonce_acc_next  = nonce_acc;
    hash_acc_next   = hash_acc;
    count_acc_next  = count_acc;
    ovf_next        = ovf;
    last_acc_next   = last_acc;
    emit            = 1'b0;
    restart         = 1'b0;
    res_next        = '0;
    found_eff       = (dcnt == 3'd0) ? (q_data.ch == "F") : found;
    pfx_len         = found_eff ? 3'd6 : 3'd5;
    dec_sum         = {1'b0, count_acc, 3'b000} + {3'b000, count_acc, 1'b0}
                      + {64'd0, q_data.nib};

    if (q_data.is_zero) begin
      emit            = 1'b1;
      restart         = 1'b1;
      res_next.status = STATUS_ZERO_BYTE;
    end else if (q_data.is_nl) begin
      emit    = 1'b1;
      restart = 1'b1;
      if (!bad && !ovf && step == S_DONE) begin
        res_next.status         = found ? STATUS_FOUND : STATUS_NONE;
        res_next.nonce          = found ? nonce_acc : 32'd0;
        res_next.hash_word      = found ? hash_acc : 32'd0;
        res_next.hash_count     = count_acc;
        res_next.last_hash_word = last_acc;
      end else begin
        res_next.status = STATUS_MALFORMED;
      end
    end else begin
      bad_next        = bad || cr_pending;
      cr_pending_next = q_data.is_cr;
      if (!q_data.is_cr && !bad_next) begin
        unique case (step)
          S_PREFIX: begin
            found_next = found_eff;
            if (prefix_char(found_eff, dcnt) != q_data.ch) begin
              bad_next = 1'b1;
            end else if (dcnt + 3'd1 == pfx_len) begin
              dcnt_next = 3'd0;
              step_next = found_eff ? S_NONCE : S_DEC_FIRST;
            end else begin
              dcnt_next = dcnt + 3'd1;
            end
          end
          S_NONCE: begin
            if (!q_data.is_hex) begin
              bad_next = 1'b1;
            end else begin
              nonce_acc_next = {nonce_acc[27:0], q_data.nib};
              dcnt_next      = dcnt + 3'd1;
              if (dcnt == 3'd7) begin
                step_next = S_SP1;
              end
            end
          end
          S_SP1: begin
            if (!q_data.is_space) begin
              bad_next = 1'b1;
            end else begin
              step_next = S_HASH;
            end
          end
          S_HASH: begin
            if (!q_data.is_hex) begin
              bad_next = 1'b1;
            end else begin
              hash_acc_next = {hash_acc[27:0], q_data.nib};
              dcnt_next     = dcnt + 3'd1;
              if (dcnt == 3'd7) begin
                step_next = S_SP2;
              end
            end
          end
          S_SP2: begin
            if (!q_data.is_space) begin
              bad_next = 1'b1;
            end else begin
              step_next = S_DEC_FIRST;
            end
          end
          S_DEC_FIRST, S_DEC_MORE: begin
            if (q_data.is_dec) begin
              if (dec_sum[67:64] != 4'd0) begin
                ovf_next = 1'b1;
              end else begin
                count_acc_next = dec_sum[63:0];
              end
              step_next = S_DEC_MORE;
            end else if (q_data.is_space && step == S_DEC_MORE) begin
              step_next = S_LAST;
              dcnt_next = 3'd0;
            end else begin
              bad_next = 1'b1;
            end
          end
          S_LAST: begin
            if (!q_data.is_hex) begin
              bad_next = 1'b1;
            end else begin
              last_acc_next = {last_acc[27:0], q_data.nib};
              dcnt_next     = dcnt + 3'd1;
              if (dcnt == 3'd7) begin
                step_next = S_DONE;
              end
            end
          end
          default: begin
            bad_next = 1'b1;
          end
        endcase
      end
      if (len == LW'(LINE_BUFFER_BYTES - 2)) begin
        emit            = 1'b1;
        restart         = 1'b1;
        res_next.status = STATUS_TOO_LONG;
      end else begin
        len_next = len + 1'b1;
      end
    end

    if (restart) begin
      step_next       = S_PREFIX;
      dcnt_next       = 3'd0;
      len_next        = '0;
      cr_pending_next = 1'b0;
      bad_next        = 1'b0;
      found_next      = 1'b0;
      nonce_acc_next  = '0;
      hash_acc_next   = '0;
      count_acc_next  = '0;
      ovf_next        = 1'b0;
      last_acc_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= S_PREFIX;
      dcnt       <= 3'd0;
      len        <= '0;
      cr_pending <= 1'b0;
      bad        <= 1'b0;
      found      <= 1'b0;
      nonce_acc  <= '0;
      hash_acc   <= '0;
      count_acc  <= '0;
      ovf        <= 1'b0;
      last_acc   <= '0;
    end else if (q_pop) begin
      step       <= step_next;
      dcnt       <= dcnt_next;
      len        <= len_next;
      cr_pending <= cr_pending_next;
      bad        <= bad_next;
      found      <= found_next;
      nonce_acc  <= nonce_acc_next;
      hash_acc   <= hash_acc_next;
      count_acc  <= count_acc_next;
      ovf        <= ovf_next;
      last_acc   <= last_acc_next;
    end
  end

  // result holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (q_pop) begin
      res_valid <= emit;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      res <= res_next;
    end
  end

endmodule

// ===== hw/rtl/poll_reply_line_parser.sv =====
// ----------------------------------------------------------------------------
// poll_reply_line_parser
// Parses FOUND / NONE poll reply lines fed one byte per transaction.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle in steady state. A byte is registered in the
// input queue before the parser can take it, and its result, when the byte
// ends a line or aborts it, is offered on the result side in the cycle after
// the parser takes it. The rate is set by the parser update, whose longest
// path is the 64-bit times-ten add of the decimal count. A held result that
// is not popped stalls the parser, and the input queue then fills and raises
// full.
`timescale 1ns / 1ps

module poll_reply_line_parser
  import prlp_pkg::*;
#(
  parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF,
  parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status,
  output logic [31:0] nonce,
  output logic [31:0] hash_word,
  output logic [63:0] hash_count,
  output logic [31:0] last_hash_word
);

`include "poll_reply_line_parser_assert.svh"

  logic        enq;
  byte_class_t enq_data;
  byte_class_t q_data;
  logic        q_valid;
  logic        q_pop;
  logic        res_valid;
  result_t     res;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  prlp_front u_front (
    .push     (push),
    .q_full   (full),
    .rx_byte  (rx_byte),
    .enq      (enq),
    .enq_data (enq_data)
  );

  prlp_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (enq),
    .wr_data   (enq_data),
    .rd        (q_pop),
    .rd_data   (q_data),
    .not_empty (q_valid),
    .is_full   (full),
    .count     (q_count)
  );

  prlp_back #(
    .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .pop       (pop),
    .res_valid (res_valid),
    .res       (res)
  );

  assign empty          = !res_valid;
  assign status         = res.status;
  assign nonce          = res.nonce;
  assign hash_word      = res.hash_word;
  assign hash_count     = res.hash_count;
  assign last_hash_word = res.last_hash_word;

  `PRLP_ASSERT_IMP(a_found_fields, !empty && status != STATUS_FOUND, nonce == 32'd0 && hash_word == 32'd0, "nonce or hash set on a non-found result")
  `PRLP_ASSERT_IMP(a_error_fields, !empty && (status == STATUS_MALFORMED || status == STATUS_ZERO_BYTE || status == STATUS_TOO_LONG), hash_count == 64'd0 && last_hash_word == 32'd0, "error result carries data")
  `PRLP_ASSERT_IMP(a_status_range, !empty, status == STATUS_NONE || status == STATUS_FOUND || status == STATUS_MALFORMED || status == STATUS_ZERO_BYTE || status == STATUS_TOO_LONG, "status code out of range")
  `PRLP_ASSERT_NEXT(a_queue_fill, enq && !q_pop, q_count != '0, "queue lost an enqueued byte")

endmodule

// ===== bench/poll_reply_line_parser_tb.sv =====
// ----------------------------------------------------------------------------
// poll_reply_line_parser_tb
// Self-checking bench: streams FOUND / NONE reply lines, broken lines, noise,
// zero bytes and overlong lines into the parser byte by byte, mirrors the
// parser state in a behavioral model and checks every status and field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module poll_reply_line_parser_tb
  import prlp_pkg::*;
;

  typedef enum logic [3:0] {
    STEP_PREFIX, STEP_NONCE, STEP_SP1, STEP_HASH, STEP_SP2,
    STEP_DEC_FIRST, STEP_DEC_MORE, STEP_LAST, STEP_DONE
  } reply_step_t;

  localparam int LINE_LIMIT = LINE_BUFFER_BYTES_DEF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  rx_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  status;
  logic [31:0] nonce;
  logic [31:0] hash_word;
  logic [63:0] hash_count;
  logic [31:0] last_hash_word;

  poll_reply_line_parser dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .rx_byte(rx_byte),
    .empty(empty), .pop(pop), .status(status), .nonce(nonce),
    .hash_word(hash_word), .hash_count(hash_count),
    .last_hash_word(last_hash_word)
  );

  // parser mirror
  reply_step_t step;
  int          digit_cnt;
  int          line_bytes;
  bit          cr_pend;
  bit          line_bad;
  bit          found_line;
  logic [31:0] nonce_acc;
  logic [31:0] hash_acc;
  logic [63:0] count_acc;
  bit          count_ovf;
  logic [31:0] last_acc;

  result_t     expected_replies[$];
  logic [7:0]  pending_bytes[$];
  logic [7:0]  line_buf[$];

  int bytes_queued = 0;
  int bytes_taken = 0;
  int lines_made = 0;
  int errors = 0;
  int status_seen[5] = '{default: 0};
  int send_gap = 0;
  int pop_stall = 0;
  int send_mode = 1;
  int recv_mode = 1;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function void restart_line();
    step = STEP_PREFIX;
    digit_cnt = 0;
    line_bytes = 0;
    cr_pend = 1'b0;
    line_bad = 1'b0;
    found_line = 1'b0;
    nonce_acc = '0;
    hash_acc = '0;
    count_acc = '0;
    count_ovf = 1'b0;
    last_acc = '0;
  endfunction

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // returns 1 once eight digits are in
  function bit shift_hex(input logic [7:0] c, inout logic [31:0] acc);
    int v;
    v = hex_nibble(c);
    if (v < 0) begin
      line_bad = 1'b1;
      return 1'b0;
    end
    acc = {acc[27:0], v[3:0]};
    digit_cnt++;
    if (digit_cnt >= 8) begin
      digit_cnt = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void parse_field_char(input logic [7:0] c);
    string       ptxt;
    int          plen;
    logic [63:0] d;
    if (line_bad) return;
    case (step)
      STEP_PREFIX: begin
        if (digit_cnt == 0) found_line = (c == "F");
        ptxt = found_line ? "FOUND " : "NONE ";
        plen = found_line ? 6 : 5;
        if (digit_cnt >= plen || ptxt[digit_cnt] != c) begin
          line_bad = 1'b1;
        end else begin
          digit_cnt++;
          if (digit_cnt == plen) begin
            digit_cnt = 0;
            step = found_line ? STEP_NONCE : STEP_DEC_FIRST;
          end
        end
      end
      STEP_NONCE: if (shift_hex(c, nonce_acc)) step = STEP_SP1;
      STEP_SP1: if (c != CH_SPACE) line_bad = 1'b1; else step = STEP_HASH;
      STEP_HASH: if (shift_hex(c, hash_acc)) step = STEP_SP2;
      STEP_SP2: if (c != CH_SPACE) line_bad = 1'b1; else step = STEP_DEC_FIRST;
      STEP_DEC_FIRST, STEP_DEC_MORE: begin
        if (c >= "0" && c <= "9") begin
          d = 64'(c - "0");
          if (count_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) count_ovf = 1'b1;
          else count_acc = count_acc * 64'd10 + d;
          step = STEP_DEC_MORE;
        end else if (c == CH_SPACE && step == STEP_DEC_MORE) begin
          step = STEP_LAST;
          digit_cnt = 0;
        end else begin
          line_bad = 1'b1;
        end
      end
      STEP_LAST: if (shift_hex(c, last_acc)) step = STEP_DONE;
      default: line_bad = 1'b1;
    endcase
  endfunction

  function void predict_reply_byte(input logic [7:0] c);
    result_t r;
    r = '0;
    if (c == CH_NUL) begin
      r.status = STATUS_ZERO_BYTE;
      expected_replies.push_back(r);
      restart_line();
      return;
    end
    if (c == CH_NL) begin
      if (!line_bad && !count_ovf && step == STEP_DONE) begin
        r.status = found_line ? STATUS_FOUND : STATUS_NONE;
        if (found_line) begin
          r.nonce = nonce_acc;
          r.hash_word = hash_acc;
        end
        r.hash_count = count_acc;
        r.last_hash_word = last_acc;
      end else begin
        r.status = STATUS_MALFORMED;
      end
      expected_replies.push_back(r);
      restart_line();
      return;
    end
    if (cr_pend) line_bad = 1'b1;
    if (c == CH_CR) begin
      cr_pend = 1'b1;
    end else begin
      cr_pend = 1'b0;
      parse_field_char(c);
    end
    line_bytes++;
    if (line_bytes >= LINE_LIMIT - 1) begin
      r.status = STATUS_TOO_LONG;
      expected_replies.push_back(r);
      restart_line();
    end
  endfunction

  task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // mostly short gaps, now and then a long one
  function int pick_gap(input int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (mode == 1) begin
      if (r < 70) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
    end
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 5);
    return $urandom_range(10, 60);
  endfunction

  // stimulus side
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      pop <= 1'b0;
    end else begin
      if (send_gap > 0 || pending_bytes.size() == 0) begin
        if (send_gap > 0) send_gap--;
        push <= 1'b0;
        rx_byte <= 8'($urandom);
      end else begin
        push <= 1'b1;
        rx_byte <= pending_bytes[0];
      end
      if (pop_stall > 0) begin
        pop_stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // transaction capture on both sides
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (push && !full) begin
        void'(pending_bytes.pop_front());
        predict_reply_byte(rx_byte);
        bytes_taken++;
        send_gap = pick_gap(send_mode);
        if (bytes_taken % 64 == 0) send_mode = $urandom_range(0, 2);
      end
      if (pop && !empty) begin
        if (status < 5) status_seen[status]++;
        if (expected_replies.size() == 0) begin
          report_mismatch("result with nothing pending, status", 64'(status), '0);
        end else begin
          want = expected_replies.pop_front();
          if (status !== want.status)
            report_mismatch("status", 64'(status), 64'(want.status));
          if (nonce !== want.nonce)
            report_mismatch("nonce", 64'(nonce), 64'(want.nonce));
          if (hash_word !== want.hash_word)
            report_mismatch("hash_word", 64'(hash_word), 64'(want.hash_word));
          if (hash_count !== want.hash_count)
            report_mismatch("hash_count", hash_count, want.hash_count);
          if (last_hash_word !== want.last_hash_word)
            report_mismatch("last_hash_word", 64'(last_hash_word), 64'(want.last_hash_word));
        end
        pop_stall = pick_gap(recv_mode);
        if ($urandom_range(0, 7) == 0) recv_mode = $urandom_range(0, 2);
      end
    end
  end

  // line building
  function void add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function void add_hex(input logic [31:0] v);
    logic [3:0] n;
    logic [7:0] base;
    for (int i = 7; i >= 0; i--) begin
      n = v[i*4 +: 4];
      base = $urandom_range(0, 1) ? "A" : "a";
      line_buf.push_back(n < 10 ? 8'("0") + 8'(n) : base + 8'(n) - 8'd10);
    end
  endfunction

  function logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == CH_NL);
    return b;
  endfunction

  function string count_text(input bit overflow);
    logic [63:0] big;
    big = {$urandom, $urandom};
    if (overflow) begin
      case ($urandom_range(0, 2))
        0: return "18446744073709551616";
        1: return $sformatf("%0d0", {1'b1, big[62:0]});
        default: return "99999999999999999999";
      endcase
    end
    case ($urandom_range(0, 5))
      0: return $sformatf("%0d", $urandom_range(0, 9));
      1: return $sformatf("%0d", $urandom_range(0, 99999));
      2: return $sformatf("%0d", big);
      3: return "18446744073709551615";
      4: return $sformatf("0000000000000000000000%0d", $urandom_range(0, 999));
      default: return $sformatf("%0d", {$urandom, 32'hFFFF_FFFF});
    endcase
  endfunction

  function void build_reply(input bit found, input string cnt);
    if (found) begin
      add_text("FOUND ");
      add_hex($urandom);
      add_text(" ");
      add_hex($urandom);
      add_text(" ");
    end else begin
      add_text("NONE ");
    end
    add_text(cnt);
    add_text(" ");
    add_hex($urandom);
  endfunction

  function void end_line();
    if ($urandom_range(0, 1)) line_buf.push_back(CH_CR);
    line_buf.push_back(CH_NL);
  endfunction

  function void flush_line();
    foreach (line_buf[i]) pending_bytes.push_back(line_buf[i]);
    bytes_queued += line_buf.size();
    line_buf.delete();
    lines_made++;
  endfunction

  function void make_random_line(input int idx);
    int kind;
    int pos;
    int n;
    kind = $urandom_range(0, 99);
    if (idx == 3) kind = 94;
    if (idx == 7) kind = 96;
    if (idx == 13) kind = 81;
    if (idx == 10) begin
      build_reply(1'b1, "18446744073709551615");
      end_line();
    end else if (kind < 60) begin
      build_reply(kind < 35, count_text(1'b0));
      end_line();
    end else if (kind < 70) begin
      build_reply($urandom_range(0, 1), count_text(1'b0));
      end_line();
      pos = $urandom_range(0, line_buf.size() - 1);
      line_buf[pos] = 8'($urandom_range(0, 255));
    end else if (kind < 76) begin
      build_reply($urandom_range(0, 1), count_text(1'b0));
      n = $urandom_range(0, line_buf.size() - 1);
      while (line_buf.size() > n) void'(line_buf.pop_back());
      end_line();
    end else if (kind < 81) begin
      build_reply($urandom_range(0, 1), count_text(1'b0));
      line_buf.insert($urandom_range(0, line_buf.size() - 1), CH_CR);
      end_line();
    end else if (kind < 86) begin
      build_reply($urandom_range(0, 1), count_text(1'b1));
      end_line();
    end else if (kind < 91) begin
      repeat ($urandom_range(1, 30)) line_buf.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) line_buf.push_back(CH_NL);
    end else if (kind < 94) begin
      build_reply($urandom_range(0, 1), count_text(1'b0));
      case ($urandom_range(0, 2))
        0: line_buf.delete($urandom_range(0, line_buf.size() - 1));
        1: line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : 8'("7"));
        default: line_buf[0] = line_buf[0] | 8'h20;
      endcase
      end_line();
    end else if (kind < 96) begin
      repeat (LINE_LIMIT - 1) line_buf.push_back(plain_byte());
    end else if (kind < 98) begin
      repeat (LINE_LIMIT - 3) line_buf.push_back(plain_byte());
      line_buf.push_back($urandom_range(0, 1) ? CH_CR : plain_byte());
      line_buf.push_back(CH_NL);
    end else begin
      build_reply($urandom_range(0, 1), count_text(1'b0));
      line_buf.insert($urandom_range(0, line_buf.size() - 1), CH_NUL);
      end_line();
    end
  endfunction

  task wait_drained();
    @(posedge clk);
    while (pending_bytes.size() != 0 || expected_replies.size() != 0) @(posedge clk);
  endtask

  initial begin
    int idx;
    restart_line();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero byte, empty line, bare carriage return, all-ones byte, mixed-case hex
    line_buf.push_back(CH_NUL);
    line_buf.push_back(CH_NL);
    line_buf.push_back(CH_CR);
    line_buf.push_back(CH_NL);
    line_buf.push_back(8'hFF);
    line_buf.push_back(CH_NL);
    add_text("NONE 0 FfFfaAa9");
    line_buf.push_back(CH_CR);
    line_buf.push_back(CH_NL);
    flush_line();
    wait_drained();

    idx = 0;
    while (bytes_queued < 1150 || lines_made < 40) begin
      make_random_line(idx);
      flush_line();
      if (idx == 20) wait_drained();
      idx++;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("%0d bytes in %0d lines: %0d none, %0d found, %0d malformed,",
             bytes_taken, lines_made, status_seen[0], status_seen[1], status_seen[2]);
    $display("%0d zero byte, %0d too long, %0d mismatches",
             status_seen[3], status_seen[4], errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
